@@ rtl/b64d_pkg.sv @@
// b64d_pkg: shared types, status codes and the character classifier
// for the base64 stream decoder; no dependencies
`timescale 1ns / 1ps

package b64d_pkg;

    // symbol codes: 0..63 data, then pad and bad
    localparam int          SYM_W   = 7;
    localparam logic [6:0]  SYM_PAD = 7'd64;
    localparam logic [6:0]  SYM_BAD = 7'd65;

    // final and sticky status codes
    localparam logic [2:0]  ST_OK       = 3'd0;
    localparam logic [2:0]  ST_BAD_CHAR = 3'd1;
    localparam logic [2:0]  ST_BAD_LEN  = 3'd2;
    localparam logic [2:0]  ST_LEFTOVER = 3'd3;
    localparam logic [2:0]  ST_BAD_PAD  = 3'd4;

    // accumulator and counter widths
    localparam int          ACC_W       = 12;
    localparam int          HELD_W      = 4;
    localparam logic [2:0]  PAD_MAX     = 3'd7;

    // default depth of the queue between front and back
    localparam int          QUEUE_DEPTH = 2;

    // one classified item as it travels through the queue
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
    } sym_item_t;

    // map an ascii byte to its 6-bit value, pad or bad
    function automatic logic [SYM_W-1:0] sym_value(input logic [7:0] c);
        logic [SYM_W-1:0] r;
        begin
            case (c) inside
                [8'h41:8'h5A]: r = SYM_W'(c - 8'h41);
                [8'h61:8'h7A]: r = SYM_W'(c - 8'h61 + 8'd26);
                [8'h30:8'h39]: r = SYM_W'(c - 8'h30 + 8'd52);
                8'h2B:         r = 7'd62;
                8'h2F:         r = 7'd63;
                8'h3D:         r = SYM_PAD;
                default:       r = SYM_BAD;
            endcase
            return r;
        end
    endfunction

endpackage

@@ rtl/base64_stream_decoder.sv @@
// base64_stream_decoder: top level tying front, queue and back together
// depends on b64d_pkg, b64d_front, b64d_queue, b64d_back
`timescale 1ns / 1ps

// Usage:
// Input channel: in_valid/in_stall carry one text character (in_char) per
// item, with in_last marking the final character of a Base64 text.
// Output channel: out_valid/out_stall carry at most one result per item:
// a decoded byte (out_byte, has_byte) whenever one completes, and on the
// last character always a result with done_res set and the final status.
// status 0 means ok; otherwise the bytes of that text are to be discarded.
// An accepted item is first written into the queue; its result is then
// held in the output register once the back end pops it from the queue.
// Throughput: one item per cycle while the receiver does not stall, set by
// the combinational decode step in the back end and its one-item-per-cycle queue pop.
// Reset clears the decoder state, empties the queue and drops out_valid.
// When the receiver stalls, the held result stays put; items that make no
// result still drain, and once the queue (QUEUE_DEPTH items) fills,
// in_stall rises until the output register is taken.
// After a last character all decoder state returns to its reset values.

module base64_stream_decoder
#(
    parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_char,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       done_res,
    output logic [2:0] status
);

    logic                q_full;
    logic                q_push;
    logic                q_pop;
    logic                q_head_valid;
    b64d_pkg::sym_item_t q_push_item;
    b64d_pkg::sym_item_t q_head_item;

    // accept and classify
    b64d_front u_front
    (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_char  (in_char),
        .in_last  (in_last),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_push_item)
    );

    // decouple front from back
    b64d_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_push_item),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_item  (q_head_item)
    );

    // decode and deliver
    b64d_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_item  (q_head_item),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .has_byte   (has_byte),
        .done_res   (done_res),
        .status     (status)
    );

endmodule

@@ rtl/b64d_front.sv @@
// b64d_front: accepts text characters and classifies them into symbols
// depends on b64d_pkg
`timescale 1ns / 1ps

module b64d_front
(
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         in_char,
    input  logic               in_last,
    input  logic               q_full,
    output logic               q_push,
    output b64d_pkg::sym_item_t q_item
);

    // stall only when the queue has no room
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // classify the character through the alphabet table
    always_comb
    begin
        q_item.sym  = b64d_pkg::sym_value(in_char);
        q_item.last = in_last;
    end

endmodule

@@ rtl/b64d_queue.sv @@
// b64d_queue: short fifo of classified items between front and back
// depends on b64d_pkg
`timescale 1ns / 1ps

module b64d_queue
#(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  b64d_pkg::sym_item_t push_item,
    input  logic                pop,
    output logic                full,
    output logic                head_valid,
    output b64d_pkg::sym_item_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64d_pkg::sym_item_t slot_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    // pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // item storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/b64d_back.sv @@
// b64d_back: bit accumulator, group and pad tracking, sticky status and
// the output register; depends on b64d_pkg
`timescale 1ns / 1ps

module b64d_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  b64d_pkg::sym_item_t head_item,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          out_byte,
    output logic                has_byte,
    output logic                done_res,
    output logic [2:0]          status
);

    localparam int ACC_W  = b64d_pkg::ACC_W;
    localparam int HELD_W = b64d_pkg::HELD_W;

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [HELD_W-1:0] held_reg, held_next;
    logic [1:0]        gpos_reg, gpos_next;
    logic [2:0]        pad_reg, pad_next;
    logic [2:0]        err_reg, err_next;

    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              has_byte_reg;
    logic              done_reg;
    logic [2:0]        status_reg;

    logic [ACC_W-1:0]  shifted;
    logic [HELD_W-1:0] held_add;
    logic              have;
    logic [7:0]        byte_val;
    logic              emit;
    logic [2:0]        res_status;

    // decode step for the item at the head of the queue
    always_comb
    begin
        acc_next  = acc_reg;
        held_next = held_reg;
        pad_next  = pad_reg;
        err_next  = err_reg;
        have      = 1'b0;
        byte_val  = '0;
        shifted   = {acc_reg[5:0], head_item.sym[5:0]};
        held_add  = held_reg + HELD_W'(6);
        if (err_reg == b64d_pkg::ST_OK)
        begin
            if (head_item.sym == b64d_pkg::SYM_BAD)
            begin
                err_next = b64d_pkg::ST_BAD_CHAR;
            end
            else if (head_item.sym == b64d_pkg::SYM_PAD)
            begin
                if (gpos_reg < 2'd2)
                begin
                    err_next = b64d_pkg::ST_BAD_PAD;
                end
                if (pad_reg != b64d_pkg::PAD_MAX)
                begin
                    pad_next = pad_reg + 1'b1;
                end
            end
            else if (pad_reg != '0)
            begin
                err_next = b64d_pkg::ST_BAD_PAD;
            end
            else
            begin
                // append six bits, peel off a byte once eight are held
                acc_next  = shifted;
                held_next = held_add;
                if (held_add >= HELD_W'(8))
                begin
                    held_next = held_add - HELD_W'(8);
                    byte_val  = 8'(shifted >> held_next);
                    acc_next  = shifted & ((ACC_W'(1) << held_next) - ACC_W'(1));
                    have      = 1'b1;
                end
            end
        end
        gpos_next = gpos_reg + 1'b1;

        // final length and leftover checks
        if (head_item.last && err_next == b64d_pkg::ST_OK)
        begin
            if (gpos_next != 2'd0)
            begin
                err_next = b64d_pkg::ST_BAD_LEN;
            end
            else if (held_next != {pad_next, 1'b0})
            begin
                err_next = b64d_pkg::ST_LEFTOVER;
            end
        end
        res_status = err_next;
        emit       = have || head_item.last;
    end

    // take the head when it makes no result or the output slot frees up
    assign pop = head_valid && (!emit || !out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            held_reg <= '0;
            gpos_reg <= '0;
            pad_reg  <= '0;
            err_reg  <= b64d_pkg::ST_OK;
        end
        else if (pop)
        begin
            if (head_item.last)
            begin
                // end of text: start the next one clean
                acc_reg  <= '0;
                held_reg <= '0;
                gpos_reg <= '0;
                pad_reg  <= '0;
                err_reg  <= b64d_pkg::ST_OK;
            end
            else
            begin
                acc_reg  <= acc_next;
                held_reg <= held_next;
                gpos_reg <= gpos_next;
                pad_reg  <= pad_next;
                err_reg  <= err_next;
            end
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            out_byte_reg <= byte_val;
            has_byte_reg <= have;
            done_reg     <= head_item.last;
            status_reg   <= res_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign has_byte  = has_byte_reg;
    assign done_res  = done_reg;
    assign status    = status_reg;

endmodule
